// File: rtl/sha1bs_pkg.sv
// ----------------------------------------------------------------------------
// sha1bs_pkg
// Types and constants shared by the byte-stream SHA-1 hasher modules.
// ----------------------------------------------------------------------------
package sha1bs_pkg;

  localparam logic [1:0] MODE_DATA     = 2'd0;
  localparam logic [1:0] MODE_DATA_FIN = 2'd1;
  localparam logic [1:0] MODE_FIN      = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd55;  // last pad index before the length field
  localparam logic [5:0] LAST_IDX = 6'd63;
  localparam logic [6:0] LAST_RND = 7'd79;
  localparam logic [2:0] LAST_WRD = 3'd4;
  localparam logic [2:0] LAST_LEN = 3'd7;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_RND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  typedef struct packed {
    logic       start;
    logic       take_byte;
    logic       finish;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream; a finish item pads the message and returns the
// five digest words.
//
//  channel | dir | tdata              | tuser                          | tlast
//  in_     | in  | [7:0] data_byte    | [1:0] mode, [2] start_message  | -
//  out_    | out | [31:0] digest_word | [2:0] word_index, [3] overflow | last_word
//
// The engine takes data bytes back to back, except while it compresses each
// full 64-byte block (load, 80 rounds, fold), one round per cycle in the
// compression unit. A finish item writes the pad and length bytes, runs one
// or two block compressions, then returns five output words. Reset is
// synchronous, active low, with no clearing pass. A small input queue and
// the output register let either side stall independently.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [2:0]  in_tuser,   // [1:0] mode, [2] start_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [3:0]  out_tuser,  // [2:0] word_index, [3] length_overflow
  output logic        out_tlast   // last_word
);
  import sha1bs_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  sha1bs_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  sha1bs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready && q_item.finish) |=> !q_ready)
    else $error("engine idle right after a finish item");

  a_words_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("gap between digest words");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser) && $stable(out_tlast)))
    else $error("output item changed while stalled");
`endif

endmodule

// File: rtl/sha1bs_front.sv
// ----------------------------------------------------------------------------
// sha1bs_front
// Input queue: decodes each incoming item and buffers it for the hash engine.
// ----------------------------------------------------------------------------
module sha1bs_front #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic [2:0]          in_tuser,   // [1:0] mode, [2] start_message
  output logic                q_valid,
  input  logic                q_ready,
  output sha1bs_pkg::item_t   q_item
);
  import sha1bs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;
  item_t              dec;

  assign in_tready = (cnt_r != CNT_W'(DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    dec.start     = in_tuser[2];
    dec.take_byte = !in_tuser[1];
    dec.finish    = (in_tuser[1:0] != MODE_DATA);
    dec.data      = in_tdata;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: rtl/sha1bs_core.sv
// ----------------------------------------------------------------------------
// sha1bs_core
// Hash engine: block buffer, padding sequencer, one-round-per-cycle SHA-1
// compression and the registered digest output.
// ----------------------------------------------------------------------------
module sha1bs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  sha1bs_pkg::item_t   q_item,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [31:0] digest_word
  output logic [3:0]          out_tuser,  // [2:0] word_index, [3] length_overflow
  output logic                out_tlast   // last_word
);
  import sha1bs_pkg::*;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    rotl1 = {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    rotl5 = {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    rotl30 = {x[1:0], x[31:2]};
  endfunction

  state_t        state_r, state_nxt;
  state_t        ret_r, ret_nxt;
  logic [31:0]   dig_r [5];
  logic [31:0]   dig_nxt [5];
  logic [511:0]  blk_r, blk_nxt;
  logic [5:0]    idx_r, idx_nxt;
  logic [63:0]   len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   a_r, b_r, c_r, d_r, e_r;
  logic [31:0]   a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [6:0]    rnd_r, rnd_nxt;
  logic          pad_first_r, pad_first_nxt;
  logic [2:0]    lcnt_r, lcnt_nxt;
  logic [2:0]    wrd_r, wrd_nxt;
  logic          ov_r, ov_nxt;
  logic [31:0]   od_r, od_nxt;
  logic [2:0]    oi_r, oi_nxt;
  logic          ol_r, ol_nxt;
  logic          oo_r, oo_nxt;

  logic [5:0]    idx_b;
  logic [63:0]   len_b;
  logic          ovf_b;
  logic [64:0]   len_sum;
  logic [63:0]   len_sh;
  logic [31:0]   w0, w2, w8, w13, wnew, f, k, tsum;

  assign q_ready    = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = {oo_r, oi_r};
  assign out_tlast  = ol_r;

  assign w0   = blk_r[511:480];
  assign w2   = blk_r[447:416];
  assign w8   = blk_r[255:224];
  assign w13  = blk_r[95:64];
  assign wnew = rotl1(w13 ^ w8 ^ w2 ^ w0);

  assign len_sh = len_r >> {lcnt_r, 3'b000};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K_RND[0];
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = K_RND[1];
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K_RND[2];
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K_RND[3];
    end
    tsum = rotl5(a_r) + f + e_r + w0 + k;
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    dig_nxt       = dig_r;
    blk_nxt       = blk_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    rnd_nxt       = rnd_r;
    pad_first_nxt = pad_first_r;
    lcnt_nxt      = lcnt_r;
    wrd_nxt       = wrd_r;
    ov_nxt        = ov_r && !out_tready;
    od_nxt        = od_r;
    oi_nxt        = oi_r;
    ol_nxt        = ol_r;
    oo_nxt        = oo_r;
    idx_b         = idx_r;
    len_b         = len_r;
    ovf_b         = ovf_r;
    len_sum       = {1'b0, len_r} + 65'd8;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.start) begin
            dig_nxt = H_INIT;
            idx_b   = '0;
            len_b   = '0;
            ovf_b   = 1'b0;
          end
          len_sum       = {1'b0, len_b} + 65'd8;
          idx_nxt       = idx_b;
          len_nxt       = len_b;
          ovf_nxt       = ovf_b;
          pad_first_nxt = 1'b1;
          state_nxt     = q_item.finish ? ST_PAD : ST_IDLE;
          if (q_item.take_byte) begin
            len_nxt = len_sum[63:0];
            ovf_nxt = ovf_b | len_sum[64];
            blk_nxt = {blk_r[503:0], q_item.data};
            idx_nxt = idx_b + 1'b1;
            if (idx_b == LAST_IDX) begin
              ret_nxt   = q_item.finish ? ST_PAD : ST_IDLE;
              state_nxt = ST_LOAD;
            end
          end
        end
      end
      ST_PAD: begin
        blk_nxt       = {blk_r[503:0], (pad_first_r ? PAD_BYTE : 8'h00)};
        idx_nxt       = idx_r + 1'b1;
        pad_first_nxt = 1'b0;
        if (idx_r == LAST_IDX) begin
          ret_nxt   = ST_PAD;
          state_nxt = ST_LOAD;
        end else if (idx_r == LEN_POS) begin
          lcnt_nxt  = LAST_LEN;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        blk_nxt  = {blk_r[503:0], len_sh[7:0]};
        idx_nxt  = idx_r + 1'b1;
        lcnt_nxt = lcnt_r - 1'b1;
        if (idx_r == LAST_IDX) begin
          ret_nxt   = ST_EMIT;
          wrd_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        a_nxt     = dig_r[0];
        b_nxt     = dig_r[1];
        c_nxt     = dig_r[2];
        d_nxt     = dig_r[3];
        e_nxt     = dig_r[4];
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        a_nxt   = tsum;
        b_nxt   = a_r;
        c_nxt   = rotl30(b_r);
        d_nxt   = c_r;
        e_nxt   = d_r;
        blk_nxt = {blk_r[479:0], wnew};
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        dig_nxt[0] = dig_r[0] + a_r;
        dig_nxt[1] = dig_r[1] + b_r;
        dig_nxt[2] = dig_r[2] + c_r;
        dig_nxt[3] = dig_r[3] + d_r;
        dig_nxt[4] = dig_r[4] + e_r;
        state_nxt  = ret_r;
      end
      ST_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt  = 1'b1;
          od_nxt  = dig_r[wrd_r];
          oi_nxt  = wrd_r;
          ol_nxt  = (wrd_r == LAST_WRD);
          oo_nxt  = ovf_r;
          wrd_nxt = wrd_r + 1'b1;
          if (wrd_r == LAST_WRD) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      dig_r       <= H_INIT;
      idx_r       <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      rnd_r       <= '0;
      pad_first_r <= 1'b0;
      lcnt_r      <= '0;
      wrd_r       <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      dig_r       <= dig_nxt;
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      rnd_r       <= rnd_nxt;
      pad_first_r <= pad_first_nxt;
      lcnt_r      <= lcnt_nxt;
      wrd_r       <= wrd_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    od_r  <= od_nxt;
    oi_r  <= oi_nxt;
    ol_r  <= ol_nxt;
    oo_r  <= oo_nxt;
  end

endmodule

// File: tb/sv/sha1_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_digest_checker
// Passive monitor for the byte-stream SHA-1 hasher. Tracks its own hash
// state from every accepted input item, queues the five digest words each
// finish should return, and compares returned words in order.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          words_checked,
  output int          spill_finishes
);
  import sha1bs_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
    logic        ovf;
  } digest_word_t;

  logic [31:0]  chain_h [5];
  logic [31:0]  blk_buf [16];
  logic [5:0]   blk_fill;
  logic [63:0]  msg_bits;
  logic         len_wrapped;
  digest_word_t words_due [$];

  int fails   = 0;
  int checked = 0;
  int spills  = 0;

  assign fail_count     = fails;
  assign words_checked  = checked;
  assign spill_finishes = spills;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, t;
    for (int i = 0; i < 16; i++) w[i] = blk_buf[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) f = (b & c) | (~b & d);
      else if (i < 40 || i >= 60) f = b ^ c ^ d;
      else f = (b & c) | (b & d) | (c & d);
      t = rol(a, 5) + f + e + w[i] + K_RND[i / 20];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endfunction

  // big-endian byte placement; a full block is compressed at once
  function automatic void absorb_byte(input logic [7:0] v);
    int sh;
    sh = (3 - int'(blk_fill[1:0])) * 8;
    blk_buf[blk_fill[5:2]][sh +: 8] = v;
    if (blk_fill == LAST_IDX) begin
      compress_block();
      blk_fill = '0;
    end else begin
      blk_fill = blk_fill + 6'd1;
    end
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
    blk_fill    = '0;
    msg_bits    = '0;
    len_wrapped = 1'b0;
  endfunction

  function automatic void predict_item(input logic [1:0] mode, input logic [7:0] data,
                                       input logic start);
    logic [63:0] grown;
    logic [63:0] len;
    if (start) restart_message();
    if (mode == MODE_DATA || mode == MODE_DATA_FIN) begin
      grown = msg_bits + 64'd8;
      if (grown < msg_bits) len_wrapped = 1'b1;
      msg_bits = grown;
      absorb_byte(data);
    end
    if (mode == MODE_DATA) return;
    if (blk_fill > LEN_POS) spills++;
    len = msg_bits;
    absorb_byte(PAD_BYTE);
    while (int'(blk_fill) != int'(LEN_POS) + 1) absorb_byte(8'h00);
    for (int k = int'(LAST_LEN); k >= 0; k--) absorb_byte(len[k*8 +: 8]);
    blk_fill = '0;
    for (int k = 0; k <= int'(LAST_WRD); k++)
      words_due.push_back('{word: chain_h[k], idx: 3'(k), last: (k == int'(LAST_WRD)),
                            ovf: len_wrapped});
  endfunction

  always @(posedge clk) begin : watch
    digest_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) blk_buf[i] = '0;
      restart_message();
      words_due.delete();
    end else begin
      if (in_tvalid && in_tready) predict_item(in_tuser[1:0], in_tdata, in_tuser[2]);
      if (out_tvalid && out_tready) begin
        if (words_due.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected digest word %h idx %0d last %b ovf %b", $realtime,
                     out_tdata, out_tuser[2:0], out_tlast, out_tuser[3]);
          fails++;
        end else begin
          want = words_due.pop_front();
          if (out_tdata !== want.word || out_tuser[2:0] !== want.idx ||
              out_tlast !== want.last || out_tuser[3] !== want.ovf) begin
            if (fails < 10)
              $display("%0t: digest mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b", $realtime,
                       want.word, want.idx, want.last, want.ovf,
                       out_tdata, out_tuser[2:0], out_tlast, out_tuser[3]);
            fails++;
          end
          checked++;
        end
      end
    end
    pending = words_due.size();
  end

endmodule

// File: tb/sv/sha1_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_tb
// Drives byte items into the SHA-1 hasher: a few known messages and special
// finishes, then random messages around the padding boundaries, restarts and
// chained digests, under random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_tb;
  import sha1bs_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, acts as a finish
  localparam int STALL_CYCLES = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS  = 200;
  localparam int ITEM_TARGET  = 260;

  typedef enum int {END_DATA_FIN, END_FIN, END_SPARE, END_OPEN} msg_end_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  int fail_count, pending, words_checked, spill_finishes;
  int snd_idle_pct = 28;
  int rcv_idle_pct = 59;
  int items_sent   = 0;
  int stall_reqs   = 0;
  int stall_served = 0;
  int quiet        = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sha1_byte_stream_hasher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sha1_digest_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending        (pending),
    .words_checked  (words_checked),
    .spill_finishes (spill_finishes)
  );

  task automatic send_item(input logic [1:0] mode, input logic [7:0] data, input logic start);
    if ($urandom_range(99, 0) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= {start, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // occasional restart in the middle of a message
  task automatic send_message(input int nbytes, input bit fresh, input msg_end_t tail);
    int cut;
    cut = (nbytes > 1 && $urandom_range(99, 0) < 8) ? int'($urandom_range(nbytes - 1, 1)) : -1;
    for (int i = 0; i < nbytes; i++)
      send_item((i == nbytes - 1 && tail == END_DATA_FIN) ? MODE_DATA_FIN : MODE_DATA,
                8'($urandom), (i == 0 && fresh) || i == cut);
    if (tail == END_FIN || tail == END_SPARE || (nbytes == 0 && tail == END_DATA_FIN))
      send_item(tail == END_SPARE ? MODE_SPARE : MODE_FIN, 8'($urandom), fresh && nbytes == 0);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99, 0);
    if (r < 65) return $urandom_range(12, 0);
    else if (r < 92) return $urandom_range(70, 48);
    else return $urandom_range(140, 100);
  endfunction

  // keeps a message's data bytes within the items left for the current phase
  function automatic int fit_length(input int room);
    int n;
    n = pick_length();
    return (n > room) ? room : n;
  endfunction

  function automatic msg_end_t pick_ending();
    int r;
    r = $urandom_range(19, 0);
    if (r < 10) return END_DATA_FIN;
    else if (r < 15) return END_FIN;
    else if (r < 18) return END_SPARE;
    else return END_OPEN;
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (stall_reqs != stall_served) begin
        stall_served = stall_reqs;
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99, 0) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d words outstanding",
               quiet, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty message, "abc", chained digests, ignored bytes, restarts, spare mode
    send_item(MODE_FIN, 8'h00, 1'b1);
    send_item(MODE_DATA, 8'h61, 1'b1);
    send_item(MODE_DATA, 8'h62, 1'b0);
    send_item(MODE_DATA_FIN, 8'h63, 1'b0);
    send_item(MODE_DATA, 8'hFF, 1'b0);
    send_item(MODE_FIN, 8'h00, 1'b0);
    send_item(MODE_FIN, 8'hFF, 1'b0);
    send_item(MODE_DATA_FIN, 8'h00, 1'b1);
    send_item(MODE_SPARE, 8'hA5, 1'b1);
    send_item(MODE_DATA, 8'h12, 1'b1);
    send_item(MODE_DATA, 8'h34, 1'b0);
    send_item(MODE_DATA, 8'hFF, 1'b1);
    send_item(MODE_SPARE, 8'h5A, 1'b0);
    send_item(MODE_FIN, 8'hFF, 1'b1);

    // last length that fits one block, first one that spills
    send_message(55, 1'b1, END_DATA_FIN);
    send_message(56, 1'b1, END_DATA_FIN);

    snd_idle_pct = 59;
    rcv_idle_pct = 28;
    while (items_sent < PHASE_ITEMS)
      send_message(fit_length(PHASE_ITEMS - items_sent), $urandom_range(99, 0) < 85,
                   pick_ending());

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    stall_reqs++;
    repeat (4) send_message($urandom_range(3, 1), 1'b1, END_DATA_FIN);
    while (items_sent < ITEM_TARGET)
      send_message(fit_length(ITEM_TARGET - items_sent), $urandom_range(99, 0) < 85,
                   pick_ending());
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d byte items; compared %0d digest words from %0d finishes.",
             items_sent, words_checked, words_checked / 5);
    $display("%0d finishes spilled padding into an extra block; output held off %0d cycles.",
             spill_finishes, STALL_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d digest words never returned", fail_count, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sha1bs_pkg.sv
rtl/sha1bs_front.sv
rtl/sha1bs_core.sv
rtl/sha1_byte_stream_hasher.sv
tb/sv/sha1_digest_checker.sv
tb/sv/sha1_byte_stream_hasher_tb.sv
